FILE: sv/cmf_pkg.sv
`default_nettype none

package cmf_pkg;

	// bar field widths
	localparam int PRICE_W = 24;
	localparam int VOL_W   = 32;
	localparam int CFG_W   = 7;
	localparam int OUT_W   = 16;

	// price differences: 2*close - low - high and |high - low|
	localparam int NUM_W  = 26;
	localparam int DEN_W  = 24;
	localparam int PROD_W = VOL_W + NUM_W;

	// flow value: signed, 8 fraction bits, magnitude saturated to 2^41 - 1
	localparam int FLOW_W     = 42;
	localparam int FLOW_FRAC  = 8;
	localparam int FLOW_QBITS = 42;

	// ratio: |flow_sum| * 128 / volume_sum, 16 quotient bits
	localparam int RATIO_SHIFT = 7;
	localparam int OUT_QBITS   = 16;

	localparam int ITER_W = 6;

	localparam int MAX_WINDOW_DEF = 64;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd20;

	localparam logic [FLOW_W-2:0] FLOW_LIMIT = '1;
	localparam logic [OUT_W-1:0]  OUT_POS_MAX = 16'h7fff;
	localparam logic [OUT_W-1:0]  OUT_NEG_MAX = 16'h8000;

	typedef struct packed {
		logic              start;
		logic [ITER_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic ovf;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: sv/cmf_divider.sv
`default_nettype none

module cmf_divider import cmf_pkg::*; #(
	parameter int DIV_W = VOL_W + 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire div_req_t              req,
	input  wire logic [DIV_W:0]        rem_init,
	input  wire logic [FLOW_QBITS-1:0] low_init,
	input  wire logic [DIV_W-1:0]      divisor,
	output div_rsp_t                   rsp,
	output logic [FLOW_QBITS-1:0]      quotient
);

	logic [ITER_W-1:0]     cnt_q;
	logic                  ovf_q;
	logic [DIV_W-1:0]      rem_q;
	logic [DIV_W-1:0]      div_q;
	logic [FLOW_QBITS-1:0] low_q;
	logic [FLOW_QBITS-1:0] quo_q;

	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic           take;

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q, low_q[FLOW_QBITS-1]};
		take  = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (req.start) begin
			cnt_q <= req.iters;
			// quotient would not fit in the requested bits
			ovf_q <= rem_init >= {1'b0, divisor};
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= rem_init[DIV_W-1:0];
			low_q <= low_init;
			div_q <= divisor;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			low_q <= {low_q[FLOW_QBITS-2:0], 1'b0};
			quo_q <= {quo_q[FLOW_QBITS-2:0], take};
		end
	end

	assign rsp.busy = cnt_q != '0;
	assign rsp.ovf  = ovf_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: sv/chaikin_money_flow_core.sv
// bars are taken one at a time: in_ready is high only in the idle state, once the
// previous bar is done; each bar runs the shared one-bit-per-cycle divider for 42
// steps for the flow value, then, once the window is full, 16 steps for the
// flow/volume ratio
// arst_n clears the sequencer, the window sums, position and fill count, and sets
// window_length to 20; ring contents are undefined until written
`default_nettype none

module chaikin_money_flow_core import cmf_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_we,
	input  wire logic [CFG_W-1:0]   cfg_wdata,
	// bar input
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [PRICE_W-1:0] high_price,
	input  wire logic [PRICE_W-1:0] low_price,
	input  wire logic [PRICE_W-1:0] close_price,
	input  wire logic [VOL_W-1:0]   bar_volume,
	input  wire logic               last_in_series,
	// result output
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [OUT_W-1:0] money_flow
);

	localparam int PTR_W  = $clog2(MAX_WINDOW);
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int FSUM_W = FLOW_W + PTR_W;
	localparam int VSUM_W = VOL_W + PTR_W;
	localparam int DIV_W  = VSUM_W;
	// split of the 66-bit flow dividend: upper bits seed the remainder
	localparam int FSPLIT = FLOW_QBITS - FLOW_FRAC;
	// split of the ratio dividend |flow_sum| << 7
	localparam int OSPLIT = OUT_QBITS - RATIO_SHIFT;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_FSTART = 3'd2;
	localparam logic [2:0] ST_FDIV   = 3'd3;
	localparam logic [2:0] ST_FWR    = 3'd4;
	localparam logic [2:0] ST_OSTART = 3'd5;
	localparam logic [2:0] ST_ODIV   = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	logic [2:0] state_q;

	// configuration and window bookkeeping
	logic [CFG_W-1:0]         wl_q;
	logic [CNT_W-1:0]         len_w;
	logic [PTR_W-1:0]         pos_q;
	logic [PTR_W-1:0]         pos_eff_q;
	logic [CNT_W-1:0]         fill_q;
	logic signed [FSUM_W-1:0] flow_sum_q;
	logic [VSUM_W-1:0]        vol_sum_q;

	// latched bar
	logic [VOL_W-1:0]  v_q;
	logic              last_q;
	logic [NUM_W-1:0]  abs_num_q;
	logic [DEN_W-1:0]  abs_den_q;
	logic              den_zero_q;
	logic              fneg_q;
	logic [PROD_W-1:0] prod_q;

	// ring stores
	logic signed [FLOW_W-1:0] flow_ring [MAX_WINDOW];
	logic [VOL_W-1:0]         volume_ring [MAX_WINDOW];
	logic signed [FLOW_W-1:0] rd_flow_q;
	logic [VOL_W-1:0]         rd_vol_q;
	logic signed [FLOW_W-1:0] flow_q;

	// ratio stage
	logic oneg_q;
	logic vzero_q;

	// output register
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] money_flow_q;

	// divider hookup
	div_req_t              div_req;
	div_rsp_t              div_rsp;
	logic [DIV_W:0]        div_rem_init;
	logic [FLOW_QBITS-1:0] div_low_init;
	logic [DIV_W-1:0]      div_divisor;
	logic [FLOW_QBITS-1:0] div_quo;

	// bar arithmetic on the input side
	logic signed [NUM_W-1:0] num_w;
	logic                    num_neg_w;
	logic                    den_neg_w;

	logic [FSUM_W-1:0]     fsum_mag_w;
	logic [FLOW_W-2:0]     fmag_w;
	logic signed [FLOW_W-1:0] flow_w;
	logic [OUT_QBITS-1:0]  oq_w;
	logic [OUT_W-1:0]      ores_w;
	logic                  out_load_w;
	logic                  full_w;

	// active window length: zero reads as one, clamp at the ring depth
	always_comb begin
		if (wl_q == '0) begin
			len_w = CNT_W'(1);
		end else if (32'(wl_q) > 32'(MAX_WINDOW)) begin
			len_w = CNT_W'(MAX_WINDOW);
		end else begin
			len_w = CNT_W'(wl_q);
		end
	end

	assign full_w = fill_q >= len_w;

	always_comb begin
		num_w = NUM_W'({1'b0, close_price, 1'b0}) - NUM_W'(low_price) - NUM_W'(high_price);
		num_neg_w = num_w[NUM_W-1];
		den_neg_w = high_price < low_price;
	end

	assign in_ready = state_q == ST_IDLE;

	// flow value from the divider result: zero for a flat bar, else saturated, with sign applied
	always_comb begin
		if (den_zero_q) begin
			fmag_w = '0;
		end else if (div_rsp.ovf || div_quo[FLOW_QBITS-1]) begin
			fmag_w = FLOW_LIMIT;
		end else begin
			fmag_w = div_quo[FLOW_W-2:0];
		end
		flow_w = fneg_q ? -$signed({1'b0, fmag_w}) : $signed({1'b0, fmag_w});
	end

	assign fsum_mag_w = flow_sum_q[FSUM_W-1] ? FSUM_W'(-flow_sum_q) : FSUM_W'(flow_sum_q);

	// divider operand selection
	always_comb begin
		div_req.start = (state_q == ST_FSTART) || (state_q == ST_OSTART);
		if (state_q == ST_OSTART) begin
			div_req.iters = ITER_W'(OUT_QBITS);
			div_rem_init  = fsum_mag_w[FSUM_W-1:OSPLIT];
			div_low_init  = {fsum_mag_w[OSPLIT-1:0], {RATIO_SHIFT{1'b0}},
				{(FLOW_QBITS-OUT_QBITS){1'b0}}};
			div_divisor   = vol_sum_q;
		end else begin
			div_req.iters = ITER_W'(FLOW_QBITS);
			div_rem_init  = (DIV_W+1)'(prod_q[PROD_W-1:FSPLIT]);
			div_low_init  = {prod_q[FSPLIT-1:0], {FLOW_FRAC{1'b0}}};
			div_divisor   = DIV_W'(abs_den_q);
		end
	end

	cmf_divider #(
		.DIV_W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.rem_init (div_rem_init),
		.low_init (div_low_init),
		.divisor  (div_divisor),
		.rsp      (div_rsp),
		.quotient (div_quo)
	);

	// ratio result with saturation, zero when the volume sum is zero
	always_comb begin
		oq_w = div_quo[OUT_QBITS-1:0];
		if (vzero_q) begin
			ores_w = '0;
		end else if (oneg_q) begin
			if (div_rsp.ovf || (oq_w > OUT_NEG_MAX)) begin
				ores_w = OUT_NEG_MAX;
			end else begin
				ores_w = OUT_W'(-oq_w);
			end
		end else if (div_rsp.ovf || oq_w[OUT_QBITS-1]) begin
			ores_w = OUT_POS_MAX;
		end else begin
			ores_w = oq_w;
		end
	end

	// result may be loaded once the previous one is gone or leaves now
	assign out_load_w = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// sequencer and window control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wl_q       <= WINDOW_RESET;
			pos_q      <= '0;
			fill_q     <= '0;
			flow_sum_q <= '0;
			vol_sum_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_FSTART;
				end
				ST_FSTART: begin
					// drop the oldest bar when the window is already full
					if (full_w) begin
						flow_sum_q <= flow_sum_q - FSUM_W'(rd_flow_q);
						vol_sum_q  <= vol_sum_q - VSUM_W'(rd_vol_q);
						fill_q     <= len_w;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= ST_FDIV;
				end
				ST_FDIV: begin
					if (!div_rsp.busy) begin
						state_q <= ST_FWR;
					end
				end
				ST_FWR: begin
					flow_sum_q <= flow_sum_q + FSUM_W'(flow_q);
					vol_sum_q  <= vol_sum_q + VSUM_W'(v_q);
					if (32'(pos_eff_q) + 32'd1 >= 32'(len_w)) begin
						pos_q <= '0;
					end else begin
						pos_q <= pos_eff_q + 1'b1;
					end
					if (full_w) begin
						state_q <= ST_OSTART;
					end else begin
						state_q <= ST_IDLE;
						if (last_q) begin
							fill_q     <= '0;
							pos_q      <= '0;
							flow_sum_q <= '0;
							vol_sum_q  <= '0;
						end
					end
				end
				ST_OSTART: begin
					state_q <= ST_ODIV;
				end
				ST_ODIV: begin
					if (!div_rsp.busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load_w) begin
						state_q <= ST_IDLE;
						// end of series: empty the window after this bar
						if (last_q) begin
							fill_q     <= '0;
							pos_q      <= '0;
							flow_sum_q <= '0;
							vol_sum_q  <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// a new window length restarts the window
			if (cfg_we) begin
				wl_q       <= cfg_wdata;
				fill_q     <= '0;
				pos_q      <= '0;
				flow_sum_q <= '0;
				vol_sum_q  <= '0;
			end
		end
	end

	// bar latch and datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			v_q        <= bar_volume;
			last_q     <= last_in_series;
			abs_num_q  <= num_neg_w ? NUM_W'(-num_w) : NUM_W'(num_w);
			abs_den_q  <= den_neg_w ? (low_price - high_price) : (high_price - low_price);
			den_zero_q <= high_price == low_price;
			fneg_q     <= num_neg_w ^ den_neg_w;
			pos_eff_q  <= (32'(pos_q) >= 32'(len_w)) ? '0 : pos_q;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(v_q) * PROD_W'(abs_num_q);
		end
		if ((state_q == ST_FDIV) && !div_rsp.busy) begin
			flow_q <= flow_w;
		end
		if (state_q == ST_OSTART) begin
			oneg_q  <= flow_sum_q[FSUM_W-1];
			vzero_q <= vol_sum_q == '0;
		end
		if (out_load_w) begin
			money_flow_q <= ores_w;
		end
	end

	// ring stores: read the oldest entry, later overwrite it with the new bar
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			rd_flow_q <= flow_ring[pos_eff_q];
			rd_vol_q  <= volume_ring[pos_eff_q];
		end
		if (state_q == ST_FWR) begin
			flow_ring[pos_eff_q]   <= flow_q;
			volume_ring[pos_eff_q] <= v_q;
		end
	end

	// output valid: set on load, cleared by a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load_w) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign money_flow = money_flow_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len_w)
		else $error("fill count beyond window length");

	a_busy_started: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(div_rsp.busy) |-> $past(div_req.start))
		else $error("divider busy without a start");

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_rsp.busy)
		else $error("input taken while divider runs");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output state");

endmodule

`default_nettype wire

FILE: tb/chaikin_money_flow_core_tb.sv
`default_nettype none

module chaikin_money_flow_core_tb;
	import cmf_pkg::*;

	localparam int WIN_MAX = MAX_WINDOW_DEF;
	localparam longint unsigned FLOW_CAP = (64'd1 << 41) - 64'd1;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_LIMIT = 20000;
	localparam int REPORT_LIMIT = 100;

	typedef struct packed {
		logic [PRICE_W-1:0] hi;
		logic [PRICE_W-1:0] lo;
		logic [PRICE_W-1:0] cl;
		logic [VOL_W-1:0]   vol;
		logic               last_bar;
	} bar_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [PRICE_W-1:0] high_price = '0;
	logic [PRICE_W-1:0] low_price = '0;
	logic [PRICE_W-1:0] close_price = '0;
	logic [VOL_W-1:0] bar_volume = '0;
	logic last_in_series = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] money_flow;

	// window model
	longint flow_store [WIN_MAX];
	logic [VOL_W-1:0] volume_store [WIN_MAX];
	longint flow_total;
	longint unsigned volume_total;
	int ring_slot;
	int bars_seen;
	logic [CFG_W-1:0] window_setting;

	logic [OUT_W-1:0] expected_flow [$];
	logic [OUT_W-1:0] want_flow;
	int failures = 0;
	int cycle_count = 0;

	// idling control
	bit tx_idle_on = 1'b1;
	bit tx_calm = 1'b0;
	bit rx_idle_on = 1'b1;
	bit rx_calm = 1'b0;
	int rx_hold_req = 0;
	int rx_hold_left = 0;

	chaikin_money_flow_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.high_price(high_price),
		.low_price(low_price),
		.close_price(close_price),
		.bar_volume(bar_volume),
		.last_in_series(last_in_series),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.money_flow(money_flow)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int active_window();
		if (window_setting < 1) return 1;
		if (window_setting > WIN_MAX) return WIN_MAX;
		return int'(window_setting);
	endfunction

	function automatic void clear_window();
		flow_total = 0;
		volume_total = 0;
		ring_slot = 0;
		bars_seen = 0;
	endfunction

	// flow value of one bar, q8, magnitude truncated and capped
	function automatic longint flow_of_bar(bar_t b);
		longint hh, ll, cc, num, den;
		longint unsigned a, d, q, r, mag;
		bit neg;
		hh = longint'(b.hi);
		ll = longint'(b.lo);
		cc = longint'(b.cl);
		num = 2 * cc - ll - hh;
		den = hh - ll;
		if (den == 0 || num == 0 || b.vol == 0) return 0;
		neg = (num < 0) != (den < 0);
		a = (num < 0) ? -num : num;
		a = a * 256;
		d = (den < 0) ? -den : den;
		q = a / d;
		r = a % d;
		if (q > FLOW_CAP / b.vol) begin
			mag = FLOW_CAP;
		end else begin
			mag = b.vol * q + (b.vol * r) / d;
			if (mag > FLOW_CAP) mag = FLOW_CAP;
		end
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	// windowed flow over volume as q1.15, saturated
	function automatic logic [OUT_W-1:0] flow_ratio();
		longint unsigned mag, q;
		logic [OUT_W-1:0] res;
		if (volume_total == 0) return '0;
		mag = (flow_total < 0) ? -flow_total : flow_total;
		q = (mag * 128) / volume_total;
		if (flow_total < 0) begin
			if (q > 32768) q = 32768;
			res = q[OUT_W-1:0];
			return -res;
		end
		if (q > 32767) q = 32767;
		return q[OUT_W-1:0];
	endfunction

	function automatic void account_bar(bar_t b);
		int len, slot;
		longint f;
		len = active_window();
		slot = (ring_slot >= len) ? 0 : ring_slot;
		f = flow_of_bar(b);
		if (bars_seen >= len) begin
			flow_total -= flow_store[slot];
			volume_total -= volume_store[slot];
			bars_seen = len;
		end else begin
			bars_seen++;
		end
		flow_store[slot] = f;
		volume_store[slot] = b.vol;
		flow_total += f;
		volume_total += b.vol;
		ring_slot = (slot + 1 >= len) ? 0 : slot + 1;
		if (bars_seen >= len) expected_flow.push_back(flow_ratio());
		if (b.last_bar) clear_window();
	endfunction

	function automatic bar_t bar(logic [PRICE_W-1:0] hi, logic [PRICE_W-1:0] lo,
			logic [PRICE_W-1:0] cl, logic [VOL_W-1:0] vol, logic last_bar);
		bar_t b;
		b.hi = hi;
		b.lo = lo;
		b.cl = cl;
		b.vol = vol;
		b.last_bar = last_bar;
		return b;
	endfunction

	function automatic logic [PRICE_W-1:0] edge_price();
		case ($urandom_range(0, 2))
			0: return '0;
			1: return '1;
			default: return PRICE_W'($urandom());
		endcase
	endfunction

	// mostly ordinary bars (low <= close <= high), some noise and extremes
	function automatic bar_t make_bar(int len);
		bar_t b;
		int span;
		case ($urandom_range(0, 9))
			0: begin
				b.hi = PRICE_W'($urandom());
				b.lo = PRICE_W'($urandom());
				b.cl = PRICE_W'($urandom());
			end
			1: begin
				b.hi = edge_price();
				b.lo = edge_price();
				b.cl = edge_price();
			end
			default: begin
				b.lo = PRICE_W'($urandom_range(0, 24'hff0000));
				span = int'($urandom_range(0, (1 << $urandom_range(0, 16)) - 1));
				b.hi = PRICE_W'(b.lo + span);
				b.cl = PRICE_W'(b.lo + $urandom_range(0, span));
			end
		endcase
		case ($urandom_range(0, 7))
			0: b.vol = '0;
			1: b.vol = '1;
			2: b.vol = $urandom_range(1, 1000);
			3, 4: b.vol = $urandom_range(0, 1 << 20);
			default: b.vol = $urandom();
		endcase
		b.last_bar = ($urandom_range(0, 4 * len) == 0);
		return b;
	endfunction

	// result check, oldest expectation first
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_flow.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$error("money_flow: no result expected, actual %0d", money_flow);
			end else begin
				want_flow = expected_flow.pop_front();
				if (money_flow !== want_flow) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$error("money_flow: expected %0d, actual %0d",
							$signed(want_flow), money_flow);
				end
			end
		end
	end

	// receiver: random stall bursts, long holds on request
	always @(posedge clk) begin
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (!rx_calm && $urandom_range(0, 199) == 0) rx_idle_on = !rx_idle_on;
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else if (!rx_calm && rx_idle_on && $urandom_range(0, 9) == 0) begin
			rx_hold_left = $urandom_range(0, 16);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// one bar transfer; valid stays up for a following bar
	task automatic send_bar(input bar_t b);
		high_price <= b.hi;
		low_price <= b.lo;
		close_price <= b.cl;
		bar_volume <= b.vol;
		last_in_series <= b.last_bar;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		account_bar(b);
	endtask

	task automatic sender_gap(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// wait for all results, then let a bar with no result finish
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_flow.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] len);
		wait_drained();
		cfg_wdata <= len;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		window_setting = len;
		clear_window();
	endtask

	task automatic run_random(input int count);
		repeat (count) begin
			if (!tx_calm && $urandom_range(0, 99) == 0) tx_idle_on = !tx_idle_on;
			if (!tx_calm && tx_idle_on && $urandom_range(0, 3) == 0)
				sender_gap($urandom_range(1, 17));
			send_bar(make_bar(active_window()));
		end
	endtask

	// reset value of the window
	task automatic test_default_window();
		run_random(60);
	endtask

	task automatic test_directed_bars();
		write_window(7'd1);
		send_bar(bar('1, '0, '1, '1, 1'b0));                   // close at high
		send_bar(bar('1, '0, '0, '1, 1'b0));                   // close at low
		send_bar(bar('1, '0, 24'h800000, '1, 1'b0));           // close near middle
		send_bar(bar('1, '0, 24'h7fffff, 32'd1, 1'b0));
		send_bar(bar(24'h123456, 24'h123456, 24'h123456, 32'd5000, 1'b0)); // flat bar
		send_bar(bar('0, '1, '1, 32'd1000, 1'b0));             // high below low
		send_bar(bar('0, '1, '0, 32'd1000, 1'b0));
		send_bar(bar(24'd10, 24'd9, '1, '1, 1'b0));            // close far outside, flow capped
		send_bar(bar(24'd10, 24'd9, '0, '1, 1'b0));
		send_bar(bar('1, 24'hfffffe, '0, 32'd1, 1'b0));
		send_bar(bar(24'd200, 24'd100, 24'd180, '0, 1'b0));     // zero volume
		send_bar(bar('0, '0, '0, '0, 1'b1));
		send_bar(bar('1, '1, '1, '1, 1'b1));
		write_window(7'd2);
		send_bar(bar(24'd10, 24'd9, '1, '1, 1'b0));            // two capped flows summed
		send_bar(bar(24'd10, 24'd9, '1, '1, 1'b0));
		send_bar(bar(24'd10, 24'd9, '0, 32'd1, 1'b0));         // negative saturation
		send_bar(bar(24'd10, 24'd9, '0, 32'd1, 1'b1));
		send_bar(bar(24'd200, 24'd100, 24'd150, 32'd7, 1'b0));
		send_bar(bar(24'd200, 24'd100, 24'd150, '0, 1'b1));
		send_bar(bar(24'd300, 24'd100, 24'd250, '0, 1'b0));     // zero volume sum
		send_bar(bar(24'd300, 24'd100, 24'd120, '0, 1'b1));
	endtask

	// zero and oversize lengths included
	task automatic test_window_sweep();
		logic [CFG_W-1:0] lengths [11];
		lengths = '{7'd0, 7'd127, 7'd64, 7'd2, 7'd3, 7'd1, 7'd33, 7'd20, 7'd65,
			7'd0, 7'd0};
		lengths[9] = CFG_W'($urandom_range(1, WIN_MAX));
		lengths[10] = CFG_W'($urandom_range(0, 127));
		foreach (lengths[i]) begin
			write_window(lengths[i]);
			run_random(130);
		end
	endtask

	// receiver holds off long enough for the core to stall its input
	task automatic test_output_backpressure();
		write_window(7'd4);
		tx_calm = 1'b1;
		rx_hold_req = 700;
		run_random(40);
		tx_calm = 1'b0;
	endtask

	task automatic test_sender_pause();
		run_random(60);
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_flow.size() != 0);
		run_random(60);
	endtask

	// full rate on both sides to the end
	task automatic test_full_rate();
		write_window(7'd10);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		run_random(150);
	endtask

	initial begin
		int drain_cycles;
		window_setting = WINDOW_RESET;
		clear_window();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_window();
		test_directed_bars();
		test_window_sweep();
		test_output_backpressure();
		test_sender_pause();
		test_full_rate();

		in_valid <= 1'b0;
		drain_cycles = 0;
		while (expected_flow.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_flow.size() != 0) begin
			failures++;
			$error("money_flow: %0d expected results never arrived", expected_flow.size());
		end
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
sv/cmf_pkg.sv
sv/cmf_divider.sv
sv/chaikin_money_flow_core.sv
tb/chaikin_money_flow_core_tb.sv
